@@ rtl/core/ple_pkg.sv @@
// Shared constants, types and codes of the positional list engine.
package ple_pkg;

   localparam int DEPTH = 16;

   localparam int VALUE_W = 32;
   localparam int POS_W = 7;
   localparam int OP_W = 3;
   localparam int STATUS_W = 2;
   localparam int ELEM_CNT_W = 5;

   // Fill count must hold DEPTH itself; a cell index only needs DEPTH - 1.
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   // Width in which positions and counts are compared without overflow.
   localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FIRST = 3'd0,
      OP_INS_LAST  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FIRST = 3'd3,
      OP_DEL_LAST  = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_READ_ALL  = 3'd6
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_POS = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_READOUT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic edit;      // apply the accepted item and load its single result
      logic rd_start;  // begin a read-out at the front cell
      logic rd_step;   // load the next read-out result
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic can_load;   // the result register is free or being emptied
      logic count_zero; // the list holds no element
      logic rd_last;    // the read-out pointer sits on the final element
   } dp_status_type;

endpackage

@@ rtl/core/ple_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface ple_req_if;
   logic                        valid;
   logic                        ready;
   logic [ple_pkg::OP_W-1:0]    op;
   logic signed [ple_pkg::VALUE_W-1:0] value;
   logic [ple_pkg::POS_W-1:0]   position;

   modport source (output valid, output op, output value, output position, input ready);
   modport sink (input valid, input op, input value, input position, output ready);
endinterface

interface ple_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ple_pkg::STATUS_W-1:0]      status;
   logic [ple_pkg::ELEM_CNT_W-1:0]    element_count;
   logic signed [ple_pkg::VALUE_W-1:0] element;
   logic                              element_valid;
   logic                              last;

   modport source (output valid, output status, output element_count, output element,
                   output element_valid, output last, input ready);
   modport sink (input valid, input status, input element_count, input element,
                 input element_valid, input last, output ready);
endinterface

@@ rtl/core/positional_list_engine.sv @@
// Top level of the positional list engine: controller and datapath.
//
// The engine holds an ordered list of up to DEPTH signed 32-bit values in a row
// of cells that shift left or right as a whole, so an insert or delete at the
// front, the back or any 1-based position is applied in the cycle in
// which the request transfer takes place, and its one status response (with
// the new element count) is ready to transfer on the next cycle. An edit that
// cannot be carried out leaves the list unchanged and reports an invalid
// position, a full list or an empty list. Edits run at one transfer per cycle
// as long as the response side keeps taking them; the response register lets
// a new request transfer in the same cycle as the previous response leaves.
// A read-all request streams the held elements front to back, one response
// per cycle while the response side keeps taking them, through the single read
// port of the cell row; requests are held off during the stream, and the final
// element carries last. A read-all of an empty list gives a single response
// marked empty. Reset clears the fill count, the response valid flag and the
// controller state only; cell contents need no clearing since cells beyond the
// count are never read.
module positional_list_engine (
   input  logic      clock,
   input  logic      reset,
   ple_req_if.sink   req_ch,
   ple_rsp_if.source rsp_ch
);

   ple_pkg::ctrl_cmd_type  cmd;
   ple_pkg::dp_status_type stat;

   // The controller decides from the opcode and the fill count whether a
   // request is an edit or the start of a read-out stream.
   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath owns the cell row, the fill count and the response register.
   ple_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_op       (req_ch.op),
      .req_value    (req_ch.value),
      .req_position (req_ch.position),
      .rsp_ch       (rsp_ch)
   );

endmodule

@@ rtl/core/ple_ctrl.sv @@
// Controller state machine sequencing edits and read-outs.
module ple_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [ple_pkg::OP_W-1:0] req_op,
   output logic                    req_ready,
   input  ple_pkg::dp_status_type  stat,
   output ple_pkg::ctrl_cmd_type   cmd
);

   ple_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ple_pkg::STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      unique case (state_ff)
         ple_pkg::STATE_IDLE: begin
            req_ready = stat.can_load;
            if (req_valid && stat.can_load) begin
               if ((ple_pkg::op_type'(req_op) == ple_pkg::OP_READ_ALL) && !stat.count_zero) begin
                  cmd.rd_start = 1'b1;
                  state_in = ple_pkg::STATE_READOUT;
               end else begin
                  cmd.edit = 1'b1;
               end
            end
         end
         ple_pkg::STATE_READOUT: begin
            if (stat.can_load) begin
               cmd.rd_step = 1'b1;
               if (stat.rd_last) begin
                  state_in = ple_pkg::STATE_IDLE;
               end
            end
         end
         default: begin
            state_in = ple_pkg::STATE_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/ple_datapath.sv @@
// Shifting cell row, fill count, read-out pointer and response register.
module ple_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  ple_pkg::ctrl_cmd_type              cmd,
   output ple_pkg::dp_status_type             stat,
   input  logic [ple_pkg::OP_W-1:0]           req_op,
   input  logic signed [ple_pkg::VALUE_W-1:0] req_value,
   input  logic [ple_pkg::POS_W-1:0]          req_position,
   ple_rsp_if.source                          rsp_ch
);

   logic signed [ple_pkg::VALUE_W-1:0] cells_ff [ple_pkg::DEPTH];
   logic signed [ple_pkg::VALUE_W-1:0] cells_in [ple_pkg::DEPTH];
   logic [ple_pkg::CNT_W-1:0] count_ff, count_in;
   logic [ple_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   ple_pkg::status_type                 rsp_status_ff, rsp_status_in;
   logic [ple_pkg::ELEM_CNT_W-1:0]      rsp_count_ff, rsp_count_in;
   logic signed [ple_pkg::VALUE_W-1:0]  rsp_element_ff, rsp_element_in;
   logic                                rsp_elem_valid_ff, rsp_elem_valid_in;
   logic                                rsp_last_ff, rsp_last_in;

   // Edit decode.
   logic [ple_pkg::CMP_W-1:0] pos_c, cnt_c;
   logic                      full, do_ins, do_del;
   logic [ple_pkg::IDX_W-1:0] edit_idx;
   ple_pkg::status_type       edit_status;

   assign full = (count_ff == ple_pkg::CNT_W'(ple_pkg::DEPTH));
   assign pos_c = ple_pkg::CMP_W'(req_position);
   assign cnt_c = ple_pkg::CMP_W'(count_ff);

   always_comb begin
      do_ins = 1'b0;
      do_del = 1'b0;
      edit_idx = '0;
      edit_status = ple_pkg::STATUS_OK;
      unique case (ple_pkg::op_type'(req_op))
         ple_pkg::OP_INS_FIRST: begin
            if (full) edit_status = ple_pkg::STATUS_FULL;
            else do_ins = 1'b1;
         end
         ple_pkg::OP_INS_LAST: begin
            edit_idx = ple_pkg::IDX_W'(count_ff);
            if (full) edit_status = ple_pkg::STATUS_FULL;
            else do_ins = 1'b1;
         end
         ple_pkg::OP_INS_AT: begin
            edit_idx = ple_pkg::IDX_W'(pos_c - ple_pkg::CMP_W'(1));
            if ((pos_c == '0) || (pos_c > cnt_c + ple_pkg::CMP_W'(1))) begin
               edit_status = ple_pkg::STATUS_BAD_POS;
            end else if (full) begin
               edit_status = ple_pkg::STATUS_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         ple_pkg::OP_DEL_FIRST: begin
            if (count_ff == '0) edit_status = ple_pkg::STATUS_EMPTY;
            else do_del = 1'b1;
         end
         ple_pkg::OP_DEL_LAST: begin
            edit_idx = ple_pkg::IDX_W'(cnt_c - ple_pkg::CMP_W'(1));
            if (count_ff == '0) edit_status = ple_pkg::STATUS_EMPTY;
            else do_del = 1'b1;
         end
         ple_pkg::OP_DEL_AT: begin
            edit_idx = ple_pkg::IDX_W'(pos_c - ple_pkg::CMP_W'(1));
            if ((pos_c == '0) || (pos_c > cnt_c)) edit_status = ple_pkg::STATUS_BAD_POS;
            else do_del = 1'b1;
         end
         ple_pkg::OP_READ_ALL: begin
            // Only reaches the edit path on an empty list.
            edit_status = ple_pkg::STATUS_EMPTY;
         end
         default: begin
            edit_status = ple_pkg::STATUS_OK;
         end
      endcase
   end

   // Cell row: every cell picks its own value, the new value, or its left or its right neighbour.
   always_comb begin
      for (int i = 0; i < ple_pkg::DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
         if (cmd.edit && do_ins) begin
            if (ple_pkg::IDX_W'(i) == edit_idx) begin
               cells_in[i] = req_value;
            end else if ((i > 0) && (ple_pkg::IDX_W'(i) > edit_idx)) begin
               cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cmd.edit && do_del) begin
            if ((i < ple_pkg::DEPTH - 1) && (ple_pkg::IDX_W'(i) >= edit_idx)) begin
               cells_in[i] = cells_ff[(i < ple_pkg::DEPTH - 1) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.edit && do_ins) count_in = count_ff + ple_pkg::CNT_W'(1);
      else if (cmd.edit && do_del) count_in = count_ff - ple_pkg::CNT_W'(1);
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.rd_start) rd_idx_in = '0;
      else if (cmd.rd_step) rd_idx_in = rd_idx_ff + ple_pkg::IDX_W'(1);
   end

   assign stat.can_load = !rsp_valid_ff || rsp_ch.ready;
   assign stat.count_zero = (count_ff == '0);
   assign stat.rd_last = ((ple_pkg::CNT_W'(rd_idx_ff) + ple_pkg::CNT_W'(1)) == count_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in = rsp_count_ff;
      rsp_element_in = rsp_element_ff;
      rsp_elem_valid_in = rsp_elem_valid_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.edit) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = edit_status;
         rsp_count_in = ple_pkg::ELEM_CNT_W'(count_in);
         rsp_element_in = '0;
         rsp_elem_valid_in = 1'b0;
         rsp_last_in = 1'b1;
      end else if (cmd.rd_step) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = ple_pkg::STATUS_OK;
         rsp_count_in = ple_pkg::ELEM_CNT_W'(count_ff);
         rsp_element_in = cells_ff[rd_idx_ff];
         rsp_elem_valid_in = 1'b1;
         rsp_last_in = stat.rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      rd_idx_ff <= rd_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff <= rsp_count_in;
      rsp_element_ff <= rsp_element_in;
      rsp_elem_valid_ff <= rsp_elem_valid_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = rsp_status_ff;
   assign rsp_ch.element_count = rsp_count_ff;
   assign rsp_ch.element = rsp_element_ff;
   assign rsp_ch.element_valid = rsp_elem_valid_ff;
   assign rsp_ch.last = rsp_last_ff;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the positional list engine: directed and random list edits.
module testbench;

   // Op code 7 is outside the defined set; the engine answers it with a plain OK.
   localparam logic [ple_pkg::OP_W-1:0] OP_UNUSED = 3'd7;
   localparam int RANDOM_PER_PHASE = 135;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES = 20;

   typedef struct {
      ple_pkg::status_type                 status;
      logic [ple_pkg::ELEM_CNT_W-1:0]      count;
      logic signed [ple_pkg::VALUE_W-1:0]  element;
      logic                                element_valid;
      logic                                last;
   } list_rsp_type;

   logic clock;
   logic reset;

   ple_req_if req_ch ();
   ple_rsp_if rsp_ch ();

   positional_list_engine uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the list, front at index 0, and the responses it predicts.
   logic signed [ple_pkg::VALUE_W-1:0] shadow_list[$];
   list_rsp_type expected_rsps[$];

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   bit growing = 1'b1;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver readiness: random idling, or a long hold-off when one is requested.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   function automatic void queue_rsp(ple_pkg::status_type status,
                                     logic signed [ple_pkg::VALUE_W-1:0] element,
                                     logic element_valid, logic last);
      list_rsp_type r;
      r.status = status;
      r.count = ple_pkg::ELEM_CNT_W'(shadow_list.size());
      r.element = element;
      r.element_valid = element_valid;
      r.last = last;
      expected_rsps.push_back(r);
   endfunction

   // Applies one accepted request to the shadow list and queues the responses it causes.
   function automatic void predict_list_op(logic [ple_pkg::OP_W-1:0] op,
                                           logic signed [ple_pkg::VALUE_W-1:0] value,
                                           logic [ple_pkg::POS_W-1:0] position);
      ple_pkg::status_type st;
      int cnt;
      int pos;
      st = ple_pkg::STATUS_OK;
      cnt = shadow_list.size();
      pos = int'(position);
      case (op)
         ple_pkg::OP_INS_FIRST: begin
            if (cnt >= ple_pkg::DEPTH) st = ple_pkg::STATUS_FULL;
            else shadow_list.push_front(value);
         end
         ple_pkg::OP_INS_LAST: begin
            if (cnt >= ple_pkg::DEPTH) st = ple_pkg::STATUS_FULL;
            else shadow_list.push_back(value);
         end
         ple_pkg::OP_INS_AT: begin
            // The position is judged before fullness.
            if (pos < 1 || pos > cnt + 1) st = ple_pkg::STATUS_BAD_POS;
            else if (cnt >= ple_pkg::DEPTH) st = ple_pkg::STATUS_FULL;
            else shadow_list.insert(pos - 1, value);
         end
         ple_pkg::OP_DEL_FIRST: begin
            if (cnt == 0) st = ple_pkg::STATUS_EMPTY;
            else void'(shadow_list.pop_front());
         end
         ple_pkg::OP_DEL_LAST: begin
            if (cnt == 0) st = ple_pkg::STATUS_EMPTY;
            else void'(shadow_list.pop_back());
         end
         ple_pkg::OP_DEL_AT: begin
            // On an empty list every position is out of range.
            if (pos < 1 || pos > cnt) st = ple_pkg::STATUS_BAD_POS;
            else shadow_list.delete(pos - 1);
         end
         ple_pkg::OP_READ_ALL: begin
            if (cnt == 0) begin
               queue_rsp(ple_pkg::STATUS_EMPTY, '0, 1'b0, 1'b1);
            end else begin
               for (int i = 0; i < cnt; i++)
                  queue_rsp(ple_pkg::STATUS_OK, shadow_list[i], 1'b1, (i == cnt - 1));
            end
            return;
         end
         default: st = ple_pkg::STATUS_OK;
      endcase
      queue_rsp(st, '0, 1'b0, 1'b1);
   endfunction

   // Offers one request, starting and ending at a falling edge. Valid is left high on
   // return so that back-to-back transfers need no gap.
   task automatic send_item(logic [ple_pkg::OP_W-1:0] op,
                            logic signed [ple_pkg::VALUE_W-1:0] value,
                            logic [ple_pkg::POS_W-1:0] position);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.value <= value;
      req_ch.position <= position;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_list_op(op, value, position);
      @(negedge clock);
   endtask

   // Stops offering and waits until every predicted response has been taken.
   task automatic drain_responses();
      req_ch.valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [ple_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return {1'b1, {(ple_pkg::VALUE_W-1){1'b0}}};
         1: return {1'b0, {(ple_pkg::VALUE_W-1){1'b1}}};
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly positions within reach of the current count, with the edges and some noise.
   function automatic logic [ple_pkg::POS_W-1:0] pick_position(int top);
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 18) return ple_pkg::POS_W'(top + 1);
      if (r < 30) return ple_pkg::POS_W'($urandom_range(0, (1 << ple_pkg::POS_W) - 1));
      if (top < 1) return ple_pkg::POS_W'(1);
      return ple_pkg::POS_W'($urandom_range(1, top));
   endfunction

   task automatic send_random_item();
      int cnt;
      int r;
      logic [ple_pkg::OP_W-1:0] op;
      logic [ple_pkg::POS_W-1:0] pos;
      cnt = shadow_list.size();
      if (cnt == ple_pkg::DEPTH) growing = 1'b0;
      else if (cnt == 0) growing = 1'b1;
      else if ($urandom_range(0, 99) < 5) growing = ~growing;
      r = $urandom_range(0, 99);
      if (r < 2) op = OP_UNUSED;
      else if (r < 10) op = ple_pkg::OP_READ_ALL;
      else if (r < 15) op = ple_pkg::OP_W'($urandom_range(0, 5));
      else if (growing == ($urandom_range(0, 99) < 75))
         op = ple_pkg::OP_W'($urandom_range(ple_pkg::OP_INS_FIRST, ple_pkg::OP_INS_AT));
      else
         op = ple_pkg::OP_W'($urandom_range(ple_pkg::OP_DEL_FIRST, ple_pkg::OP_DEL_AT));
      if (op == ple_pkg::OP_INS_AT) pos = pick_position(cnt + 1);
      else if (op == ple_pkg::OP_DEL_AT) pos = pick_position(cnt);
      else pos = ple_pkg::POS_W'($urandom_range(0, (1 << ple_pkg::POS_W) - 1));
      send_item(op, pick_value(), pos);
   endtask

   // Every delete and the read-out on an empty list, and the two insert positions refused there.
   task automatic test_empty_list();
      send_item(ple_pkg::OP_READ_ALL, '0, '0);
      send_item(ple_pkg::OP_DEL_FIRST, '0, '0);
      send_item(ple_pkg::OP_DEL_LAST, '0, '0);
      send_item(ple_pkg::OP_DEL_AT, '0, ple_pkg::POS_W'(1));
      send_item(ple_pkg::OP_DEL_AT, '0, '0);
      send_item(ple_pkg::OP_INS_AT, 32'h1234_5678, '0);
      send_item(ple_pkg::OP_INS_AT, 32'h1234_5678, ple_pkg::POS_W'(2));
      send_item(OP_UNUSED, 32'hFFFF_FFFF, '1);
      drain_responses();
   endtask

   // Fills the list with value extremes at every insert site, then tries to overflow it, and deletes and reads it back.
   task automatic test_fill_and_overflow();
      send_item(ple_pkg::OP_INS_AT, 32'sh8000_0000, ple_pkg::POS_W'(1));
      send_item(ple_pkg::OP_INS_FIRST, 32'sh7FFF_FFFF, '0);
      send_item(ple_pkg::OP_INS_LAST, '0, '0);
      send_item(ple_pkg::OP_INS_LAST, '1, '0);
      send_item(ple_pkg::OP_INS_AT, 32'h5555_5555, ple_pkg::POS_W'(3));
      send_item(ple_pkg::OP_INS_AT, 32'hAAAA_AAAA, ple_pkg::POS_W'(6));
      while (shadow_list.size() < ple_pkg::DEPTH)
         send_item(($urandom_range(0, 1) != 0) ? ple_pkg::OP_INS_FIRST : ple_pkg::OP_INS_LAST,
                   pick_value(), '0);
      send_item(ple_pkg::OP_INS_FIRST, 32'h0BAD_0001, '0);
      send_item(ple_pkg::OP_INS_LAST, 32'h0BAD_0002, '0);
      send_item(ple_pkg::OP_INS_AT, 32'h0BAD_0003, ple_pkg::POS_W'(ple_pkg::DEPTH + 1));
      send_item(ple_pkg::OP_INS_AT, 32'h0BAD_0004, ple_pkg::POS_W'(ple_pkg::DEPTH + 2));
      send_item(ple_pkg::OP_DEL_AT, '0, ple_pkg::POS_W'(ple_pkg::DEPTH + 1));
      send_item(ple_pkg::OP_READ_ALL, '0, '0);
      send_item(ple_pkg::OP_DEL_AT, '0, ple_pkg::POS_W'(ple_pkg::DEPTH));
      send_item(ple_pkg::OP_DEL_AT, '0, ple_pkg::POS_W'(1));
      send_item(ple_pkg::OP_READ_ALL, '0, '0);
      drain_responses();
   endtask

   // The receiver stops for a long stretch while requests keep coming, so the engine
   // must fill its response register and refuse further transfers until it drains.
   task automatic test_backpressure();
      @(posedge clock);
      hold_request = HOLD_OFF_CYCLES;
      @(negedge clock);
      repeat (40) send_random_item();
      drain_responses();
   endtask

   task automatic test_random_traffic(int n);
      repeat (n) send_random_item();
      drain_responses();
   endtask

   // Response checker: each transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            $error("response transfer with nothing expected: status %0d count %0d",
                   rsp_ch.status, rsp_ch.element_count);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.element_count !== want.count) begin
               $error("element_count: expected %0d, actual %0d", want.count,
                      rsp_ch.element_count);
               error_count++;
            end
            if (rsp_ch.element !== want.element) begin
               $error("element: expected %0d, actual %0d", want.element, rsp_ch.element);
               error_count++;
            end
            if (rsp_ch.element_valid !== want.element_valid) begin
               $error("element_valid: expected %0d, actual %0d", want.element_valid,
                      rsp_ch.element_valid);
               error_count++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
               error_count++;
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.op = '0;
      req_ch.value = '0;
      req_ch.position = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Sender idles lightly, receiver heavily.
      send_idle_pct = 17;
      recv_idle_pct = 68;
      test_empty_list();
      test_fill_and_overflow();
      test_random_traffic(RANDOM_PER_PHASE);

      // Roles swapped.
      send_idle_pct = 68;
      recv_idle_pct = 17;
      test_random_traffic(RANDOM_PER_PHASE);

      // Full rate on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_traffic(RANDOM_PER_PHASE);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d predicted responses never arrived", expected_rsps.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
